[hdl/rrl_pkg.sv]
// ----------------------------------------------------------------------------
// rrl_pkg
// Shared types and constants for the row run-length band fill block.
// ----------------------------------------------------------------------------
package rrl_pkg;

   localparam int RRL_MAX_RUN_THRESHOLD = 32;
   localparam int SAMPLE_W              = 8;
   localparam int MIN_RUN_W             = 6;
   localparam int CSR_ADDR_W            = 5;
   localparam int CSR_DATA_W            = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_TRACE_LEVEL    = 3'd0;
   localparam logic [2:0] REG_BAND_HALFWIDTH = 3'd1;
   localparam logic [2:0] REG_FILL_LONG_RUNS = 3'd2;
   localparam logic [2:0] REG_MIN_RUN_LENGTH = 3'd3;
   localparam logic [2:0] REG_FILL_VALUE     = 3'd4;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  trace_level;
      logic [SAMPLE_W-1:0]  band_halfwidth;
      logic                 fill_long_runs;
      logic [MIN_RUN_W-1:0] min_run_length;
      logic [SAMPLE_W-1:0]  fill_value;
   } rrl_cfg_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } rrl_state_type;

endpackage

[hdl/rrl_cell.sv]
// ----------------------------------------------------------------------------
// rrl_cell
// One slot of the run-holding chain: loads a new sample or takes its
// upstream neighbor's sample when the chain advances toward the head.
// ----------------------------------------------------------------------------
module rrl_cell (
   input  logic                         clock,
   input  logic                         shift,
   input  logic                         load,
   input  logic [rrl_pkg::SAMPLE_W-1:0] load_sample,
   input  logic [rrl_pkg::SAMPLE_W-1:0] next_sample,
   output logic [rrl_pkg::SAMPLE_W-1:0] sample_q
);
   import rrl_pkg::*;

   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] sample_in;

   always_comb begin
      priority if (shift) begin
         sample_in = next_sample;
      end else if (load) begin
         sample_in = load_sample;
      end else begin
         sample_in = sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample_q = sample_ff;

endmodule

[hdl/rrl_csr.sv]
// ----------------------------------------------------------------------------
// rrl_csr
// APB-style register file holding the band, threshold and fill settings.
// ----------------------------------------------------------------------------
module rrl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rrl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rrl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rrl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output rrl_pkg::rrl_cfg_type           cfg
);
   import rrl_pkg::*;

   rrl_cfg_type cfg_ff;
   rrl_cfg_type cfg_in;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TRACE_LEVEL:    cfg_in.trace_level    = csr_pwdata[SAMPLE_W-1:0];
            REG_BAND_HALFWIDTH: cfg_in.band_halfwidth = csr_pwdata[SAMPLE_W-1:0];
            REG_FILL_LONG_RUNS: cfg_in.fill_long_runs = csr_pwdata[0];
            REG_MIN_RUN_LENGTH: cfg_in.min_run_length = csr_pwdata[MIN_RUN_W-1:0];
            REG_FILL_VALUE:     cfg_in.fill_value     = csr_pwdata[SAMPLE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trace_level    <= '0;
         cfg_ff.band_halfwidth <= '0;
         cfg_ff.fill_long_runs <= 1'b1;
         cfg_ff.min_run_length <= MIN_RUN_W'(1);
         cfg_ff.fill_value     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_TRACE_LEVEL:    csr_prdata[SAMPLE_W-1:0]  = cfg_ff.trace_level;
         REG_BAND_HALFWIDTH: csr_prdata[SAMPLE_W-1:0]  = cfg_ff.band_halfwidth;
         REG_FILL_LONG_RUNS: csr_prdata[0]             = cfg_ff.fill_long_runs;
         REG_MIN_RUN_LENGTH: csr_prdata[MIN_RUN_W-1:0] = cfg_ff.min_run_length;
         REG_FILL_VALUE:     csr_prdata[SAMPLE_W-1:0]  = cfg_ff.fill_value;
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[hdl/row_run_length_band_fill.sv]
// ----------------------------------------------------------------------------
// row_run_length_band_fill
// Replaces in-band sample runs of a row by a fill value: long runs if fill_long_runs, else short runs.
// ----------------------------------------------------------------------------
// Usage: the req channel takes one sample per beat with a row-end flag; the
// rsp channel gives the output samples in pixel order, burst_last marking the
// last beat caused by one request and row_done the row's last pixel. Both
// channels use valid/stall; the csr port is an APB-style register port.
// A result appears on rsp in the cycle after the request edge. An in-band
// sample whose fate is still open is held in a chain of cells and gives no
// beat. The request that settles a run of held samples gives no beat at
// its own edge; then the chain drains one held sample per cycle from its
// head cell while the receiver does not stall, and the request's own beat
// follows; req_stall stays high meanwhile.
// All other requests are taken without a wait, so the sustained rate is one
// pixel per cycle outside run releases and receiver stalls.
// When the receiver stalls, the output register holds its beat and
// req_stall rises. Reset empties the run chain, clears the output valid flag
// and loads the register defaults.
// ----------------------------------------------------------------------------
module row_run_length_band_fill #(
   parameter int MAX_RUN_THRESHOLD = rrl_pkg::RRL_MAX_RUN_THRESHOLD
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rrl_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                           req_row_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rrl_pkg::SAMPLE_W-1:0]   rsp_value,
   output logic                           rsp_burst_last,
   output logic                           rsp_row_done,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rrl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rrl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rrl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rrl_pkg::*;

   localparam int DEPTH = MAX_RUN_THRESHOLD - 1;
   localparam int CW    = $clog2(MAX_RUN_THRESHOLD);
   localparam int TW    = CW + 1;

   rrl_cfg_type   cfg;
   rrl_state_type state_ff, state_in;

   logic [CW-1:0]       count_ff, count_in;
   logic                decided_ff, decided_in;
   logic [SAMPLE_W-1:0] pend_value_ff, pend_value_in;
   logic                pend_row_ff, pend_row_in;
   logic                flush_fill_ff, flush_fill_in;

   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_value_ff;
   logic                rsp_burst_last_ff;
   logic                rsp_row_done_ff;

   logic                emit;
   logic [SAMPLE_W-1:0] emit_value;
   logic                emit_last;
   logic                emit_row;
   logic                cell_load;
   logic                cell_shift;

   logic                out_free;
   logic                accept;
   logic                in_band;
   logic                run_sample;
   logic [6:0]          thr_raw;
   logic [TW-1:0]       thr;
   logic [TW-1:0]       count_next_len;
   logic                hold_case;
   logic                decide_case;
   logic                pass_case;
   logic                close_case;
   logic                start_drain;
   logic [SAMPLE_W-1:0] run_out;

   logic [SAMPLE_W-1:0] cell_q [DEPTH];

   rrl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // run chain: head cell 0 drains, each cell but the tail takes its upstream neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [SAMPLE_W-1:0] upstream;
      if (i == DEPTH - 1) begin : g_tail
         assign upstream = cell_q[i];
      end else begin : g_mid
         assign upstream = cell_q[i+1];
      end
      rrl_cell u_cell (
         .clock       (clock),
         .shift       (cell_shift),
         .load        (cell_load && (count_ff == CW'(i))),
         .load_sample (req_sample),
         .next_sample (upstream),
         .sample_q    (cell_q[i])
      );
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // open band test: t - h < s < t + h
   assign in_band = (({1'b0, req_sample} + {1'b0, cfg.band_halfwidth}) > {1'b0, cfg.trace_level})
                 && ({1'b0, req_sample} < ({1'b0, cfg.trace_level} + {1'b0, cfg.band_halfwidth}));
   assign run_sample = in_band && !req_row_end;

   // saturate the threshold to MAX_RUN_THRESHOLD, one more than the chain size; zero acts as one
   always_comb begin
      thr_raw = {1'b0, cfg.min_run_length};
      if (thr_raw > 7'(MAX_RUN_THRESHOLD)) begin
         thr_raw = 7'(MAX_RUN_THRESHOLD);
      end else if (thr_raw == 7'd0) begin
         thr_raw = 7'd1;
      end
      thr = thr_raw[TW-1:0];
   end

   assign count_next_len = {1'b0, count_ff} + TW'(1);
   assign hold_case      = run_sample && !decided_ff && (count_next_len < thr);
   assign decide_case    = run_sample && !decided_ff && !hold_case;
   assign pass_case      = run_sample && decided_ff;
   assign close_case     = !run_sample;
   assign start_drain    = accept && (count_ff != '0)
                        && (decide_case || (close_case && !decided_ff));
   assign run_out        = cfg.fill_long_runs ? cfg.fill_value : req_sample;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_drain) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free && (count_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      emit          = 1'b0;
      emit_value    = pend_value_ff;
      emit_last     = 1'b1;
      emit_row      = 1'b0;
      count_in      = count_ff;
      decided_in    = decided_ff;
      pend_value_in = pend_value_ff;
      pend_row_in   = pend_row_ff;
      flush_fill_in = flush_fill_ff;
      cell_load     = 1'b0;
      cell_shift    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (hold_case) begin
                  cell_load = 1'b1;
                  count_in  = count_next_len[CW-1:0];
               end else if (pass_case) begin
                  emit       = 1'b1;
                  emit_value = run_out;
               end else if (decide_case) begin
                  decided_in    = 1'b1;
                  pend_value_in = run_out;
                  pend_row_in   = 1'b0;
                  flush_fill_in = cfg.fill_long_runs;
                  if (count_ff == '0) begin
                     emit       = 1'b1;
                     emit_value = run_out;
                  end
               end else begin
                  decided_in    = 1'b0;
                  pend_value_in = req_sample;
                  pend_row_in   = req_row_end;
                  flush_fill_in = !cfg.fill_long_runs;
                  if (decided_ff || (count_ff == '0)) begin
                     emit       = 1'b1;
                     emit_value = req_sample;
                     emit_row   = req_row_end;
                     count_in   = '0;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               emit = 1'b1;
               if (count_ff != '0) begin
                  // release the head cell, advance the chain
                  emit_value = flush_fill_ff ? cfg.fill_value : cell_q[0];
                  emit_last  = 1'b0;
                  cell_shift = 1'b1;
                  count_in   = count_ff - CW'(1);
               end else begin
                  emit_value = pend_value_ff;
                  emit_row   = pend_row_ff;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         decided_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         decided_ff <= decided_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      pend_row_ff   <= pend_row_in;
      flush_fill_ff <= flush_fill_in;
      if (emit) begin
         rsp_value_ff      <= emit_value;
         rsp_burst_last_ff <= emit_last;
         rsp_row_done_ff   <= emit_row;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_burst_last = rsp_burst_last_ff;
   assign rsp_row_done   = rsp_row_done_ff;

endmodule
